@@ sv/tswb_pkg.sv @@
package tswb_pkg;

  // ring depth default and field widths
  localparam int unsigned DEPTH_DEF   = 1024;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned OFF_W       = 10;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned CNT_OUT_W   = 11;
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam logic [STAMP_W-1:0] MAX_AGE_RST = 32'd1000000;

  // operation codes carried in the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_EXPIRE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // input item payload, sample_time in the lowest bits
  typedef struct packed {
    logic [OFF_W-1:0]   read_offset;
    logic [POS_W-1:0]   pos_z;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_x;
    logic [STAMP_W-1:0] sample_time;
  } in_item_t;

  // result item payload, sample_count in the lowest bits
  typedef struct packed {
    logic [POS_W-1:0]     read_z;
    logic [POS_W-1:0]     read_y;
    logic [POS_W-1:0]     read_x;
    logic [STAMP_W-1:0]   read_time;
    logic [CNT_OUT_W-1:0] sample_count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic do_add;
    logic do_clear;
    logic do_read;
    logic exp_start;
    logic exp_drop;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic exp_over;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/tswb_ctrl.sv @@
module tswb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  tswb_pkg::func_e        func_i,
  input  tswb_pkg::dp_status_t   status_i,
  output logic                   in_ready_o,
  output tswb_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXPIRE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EMIT;
          unique case (func_i)
            tswb_pkg::FUNC_ADD:   cmd_o.do_add = 1'b1;
            tswb_pkg::FUNC_CLEAR: cmd_o.do_clear = 1'b1;
            tswb_pkg::FUNC_READ:  cmd_o.do_read = 1'b1;
            tswb_pkg::FUNC_EXPIRE: begin
              if (!status_i.count_zero) begin
                cmd_o.exp_start = 1'b1;
                state_d         = ST_EXPIRE;
              end
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_EXPIRE: begin
        // one oldest entry checked per cycle
        if (status_i.exp_over) begin
          cmd_o.exp_drop = 1'b1;
          if (status_i.count_one) begin
            state_d = ST_EMIT;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/tswb_dp.sv @@
module tswb_dp #(
  parameter int unsigned DEPTH = tswb_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tswb_pkg::STAMP_W-1:0]      cfg_wdata_i,
  input  tswb_pkg::in_item_t                item_i,
  input  tswb_pkg::ctrl_cmd_t               cmd_i,
  input  logic                              out_ready_i,
  output tswb_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  output tswb_pkg::out_item_t               out_item_o,
  output logic                              out_stored_o,
  output logic                              out_read_valid_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = tswb_pkg::OFF_W;
  localparam int unsigned SW = ((CW > OW) ? CW : OW) + 1;
  localparam int unsigned TW = tswb_pkg::STAMP_W;
  localparam int unsigned PW = tswb_pkg::POS_W;
  localparam int unsigned MW = TW + 3 * PW;

  logic [IW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [TW-1:0] last_q, last_d;
  logic [TW-1:0] max_age_q;

  logic [MW-1:0] mem_q [DEPTH];
  logic [MW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] raddr, wslot, rslot, nxt_oldest;
  logic [SW-1:0] wsum, rsum;
  logic          is_new, full, off_in_range;
  logic [TW-1:0] age;

  logic                stored_q, rvalid_q;
  logic                out_valid_q;
  tswb_pkg::out_item_t out_q;
  logic                out_stored_q, out_rvalid_q;
  logic [MW-1:0]       rd_masked;

  // ring slot arithmetic, the write slot sum stays below twice the depth
  assign wsum  = SW'(oldest_q) + SW'(count_q);
  assign wslot = (wsum >= SW'(DEPTH)) ? IW'(wsum - SW'(DEPTH)) : IW'(wsum);
  assign rsum  = SW'(oldest_q) + SW'(item_i.read_offset);
  assign rslot = (rsum >= SW'(DEPTH)) ? IW'(rsum - SW'(DEPTH)) : IW'(rsum);
  assign nxt_oldest = (oldest_q == IW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  assign is_new       = (item_i.sample_time != last_q);
  assign full         = (count_q == CW'(DEPTH));
  assign off_in_range = (SW'(item_i.read_offset) < SW'(count_q));

  // ring state update and memory control
  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    last_d   = last_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    raddr    = oldest_q;
    if (cmd_i.do_add && is_new) begin
      mem_we = 1'b1;
      last_d = item_i.sample_time;
      if (full) begin
        oldest_d = nxt_oldest;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.do_clear) begin
      count_d = '0;
    end
    if (cmd_i.do_read) begin
      mem_re = 1'b1;
      raddr  = rslot;
    end
    if (cmd_i.exp_start) begin
      mem_re = 1'b1;
      raddr  = oldest_q;
    end
    if (cmd_i.exp_drop) begin
      oldest_d = nxt_oldest;
      count_d  = count_q - 1'b1;
      mem_re   = 1'b1;
      raddr    = nxt_oldest;
    end
  end

  // sample memory, stamp in the low word
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wslot] <= {item_i.pos_z, item_i.pos_y, item_i.pos_x, item_i.sample_time};
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // age of the oldest entry against the last stamp
  assign age = last_q - rdata_q[TW-1:0];

  assign status_o.count_zero = (count_q == '0);
  assign status_o.count_one  = (count_q == CW'(1));
  assign status_o.exp_over   = (age > max_age_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // ring pointers, config and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      count_q   <= '0;
      last_q    <= '0;
      max_age_q <= tswb_pkg::MAX_AGE_RST;
      stored_q  <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      last_q   <= last_d;
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        stored_q <= cmd_i.do_add && is_new;
        rvalid_q <= cmd_i.do_read && off_in_range;
      end
    end
  end

  // read fields are zero unless a valid read
  assign rd_masked = rdata_q & {MW{rvalid_q}};

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.sample_count <= tswb_pkg::CNT_OUT_W'(count_q);
      out_q.read_time    <= rd_masked[TW-1:0];
      out_q.read_x       <= rd_masked[TW+PW-1:TW];
      out_q.read_y       <= rd_masked[TW+2*PW-1:TW+PW];
      out_q.read_z       <= rd_masked[MW-1:TW+2*PW];
      out_stored_q       <= stored_q;
      out_rvalid_q       <= rvalid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;
  assign out_stored_o     = out_stored_q;
  assign out_read_valid_o = out_rvalid_q;

endmodule

@@ sv/timed_sample_window_buffer.sv @@
// Ring buffer of time-stamped position samples.
// Input stream: tuser carries the operation (add, expire, clear, read), tdata
// the stamp, the three position words and the read offset. Output stream:
// one result item per input item with the sample count and, for a read, the
// entry found; tuser flags whether an add stored and whether a read was valid.
// max_age is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Add, clear and read: the accept cycle updates the ring or issues the memory
// read, then ST_EMIT loads the output register once that register is free.
// Expire walks the oldest entries one per cycle through the single memory
// read port; an empty buffer skips the walk, and the walk stops at the first
// entry within max_age or when it drains the buffer.
// Reset clears the count, the oldest index and the last stamp and loads
// max_age with 1000000; the sample memory is not cleared.
// When the receiver stalls, the result waits in the output register and the
// next item can be accepted; its result waits until that register is free.
module timed_sample_window_buffer #(
  parameter int unsigned DEPTH = tswb_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tswb_pkg::STAMP_W-1:0]         cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_time, pos_x, pos_y, pos_z, read_offset, zero fill
  input  logic [tswb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func
  input  logic [tswb_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sample_count, read_time, read_x, read_y, read_z, zero fill
  output logic [tswb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // stored, read_valid
  output logic [tswb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

  localparam int unsigned IN_ITEM_W  = $bits(tswb_pkg::in_item_t);
  localparam int unsigned OUT_ITEM_W = $bits(tswb_pkg::out_item_t);

  tswb_pkg::ctrl_cmd_t  cmd;
  tswb_pkg::dp_status_t status;
  tswb_pkg::in_item_t   in_item;
  tswb_pkg::out_item_t  out_item;
  tswb_pkg::func_e      func;
  logic                 out_stored, out_read_valid;

  // unpack the input item
  assign in_item = tswb_pkg::in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
  assign func    = tswb_pkg::func_e'(s_axis_tuser);

  tswb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .func_i     (func),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  tswb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .item_i           (in_item),
    .cmd_i            (cmd),
    .out_ready_i      (m_axis_tready),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid),
    .out_item_o       (out_item),
    .out_stored_o     (out_stored),
    .out_read_valid_o (out_read_valid)
  );

  // pack the result item
  assign m_axis_tdata = {{(tswb_pkg::OUT_TDATA_W - OUT_ITEM_W){1'b0}}, out_item};
  assign m_axis_tuser = {out_read_valid, out_stored};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH     = tswb_pkg::DEPTH_DEF;
  localparam int unsigned LIMIT     = 500000;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned SETTLE    = 8;
  localparam int unsigned FILL_ADDS = 1030;
  localparam int unsigned PHASE_N   = 30;

  // one result item as the block should deliver it
  typedef struct {
    logic [tswb_pkg::CNT_OUT_W-1:0] count;
    logic                           stored;
    logic                           rvalid;
    logic [tswb_pkg::STAMP_W-1:0]   rtime;
    logic [tswb_pkg::POS_W-1:0]     rx;
    logic [tswb_pkg::POS_W-1:0]     ry;
    logic [tswb_pkg::POS_W-1:0]     rz;
  } window_result_t;

  // one directed stimulus row, with an optional hand-typed result
  typedef struct {
    tswb_pkg::func_e    op;
    tswb_pkg::in_item_t it;
    bit                 typed;
    window_result_t     want;
  } dir_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [tswb_pkg::STAMP_W-1:0]     cfg_wdata = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [tswb_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [tswb_pkg::FUNC_W-1:0]      s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [tswb_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [tswb_pkg::OUT_TUSER_W-1:0] m_tuser;

  timed_sample_window_buffer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the ring and its register
  bit   [tswb_pkg::STAMP_W-1:0] ring_stamp [DEPTH];
  bit   [3*tswb_pkg::POS_W-1:0] ring_pos [DEPTH];
  int unsigned                  oldest_ptr = 0;
  int unsigned                  held = 0;
  logic [tswb_pkg::STAMP_W-1:0] newest_stamp = '0;
  logic [tswb_pkg::STAMP_W-1:0] age_limit = tswb_pkg::MAX_AGE_RST;

  window_result_t pending_results[$];
  dir_row_t       dir_rows[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  bit             hold_req = 1'b0;
  int unsigned    hold_left = 0;

  function automatic int unsigned ring_slot(int unsigned off);
    return (oldest_ptr + off) % DEPTH;
  endfunction

  // expected result of one item, advancing the shadow ring
  function automatic window_result_t apply_window_op(tswb_pkg::func_e op,
                                                     tswb_pkg::in_item_t it);
    window_result_t               r;
    int unsigned                  slot;
    logic [tswb_pkg::STAMP_W-1:0] age;
    r = '{count: '0, stored: 1'b0, rvalid: 1'b0, rtime: '0, rx: '0, ry: '0, rz: '0};
    case (op)
      tswb_pkg::FUNC_ADD: begin
        if (it.sample_time != newest_stamp) begin
          slot = ring_slot(held);
          ring_stamp[slot] = it.sample_time;
          ring_pos[slot] = {it.pos_z, it.pos_y, it.pos_x};
          if (held < DEPTH) held++;
          else oldest_ptr = ring_slot(1);
          newest_stamp = it.sample_time;
          r.stored = 1'b1;
        end
      end
      tswb_pkg::FUNC_EXPIRE: begin
        // wrapping age of the oldest entry against the newest stamp
        age = newest_stamp - ring_stamp[oldest_ptr];
        while (held > 0 && age > age_limit) begin
          oldest_ptr = ring_slot(1);
          held--;
          age = newest_stamp - ring_stamp[oldest_ptr];
        end
      end
      tswb_pkg::FUNC_CLEAR: begin
        held = 0;
      end
      default: begin
        if (32'(it.read_offset) < held) begin
          slot = ring_slot(32'(it.read_offset));
          r.rvalid = 1'b1;
          r.rtime = ring_stamp[slot];
          {r.rz, r.ry, r.rx} = ring_pos[slot];
        end
      end
    endcase
    r.count = held[tswb_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic add_row(tswb_pkg::func_e op, logic [31:0] st, logic [31:0] x,
                         logic [31:0] y, logic [31:0] z,
                         logic [tswb_pkg::OFF_W-1:0] off, bit typed,
                         logic [tswb_pkg::CNT_OUT_W-1:0] cnt, bit sto, bit vld);
    dir_row_t row;
    row.op = op;
    row.it.sample_time = st;
    row.it.pos_x = x;
    row.it.pos_y = y;
    row.it.pos_z = z;
    row.it.read_offset = off;
    row.typed = typed;
    row.want = '{count: cnt, stored: sto, rvalid: vld, rtime: '0, rx: '0, ry: '0, rz: '0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // offer one item, wait for acceptance, then record what it should give
  task automatic offer_item(tswb_pkg::func_e op, tswb_pkg::in_item_t it, bit typed,
                            window_result_t want);
    logic [tswb_pkg::IN_TDATA_W-1:0] word;
    window_result_t                  pred;
    word = '0;
    word[$bits(tswb_pkg::in_item_t)-1:0] = it;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= op;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pred = apply_window_op(op, it);
    pending_results.insert(pending_results.size(), typed ? want : pred);
  endtask

  task automatic offer_plain(tswb_pkg::func_e op, tswb_pkg::in_item_t it);
    window_result_t none;
    none = '{count: '0, stored: 1'b0, rvalid: 1'b0, rtime: '0, rx: '0, ry: '0, rz: '0};
    offer_item(op, it, 1'b0, none);
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_age(logic [tswb_pkg::STAMP_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    age_limit = v;
  endtask

  // mostly well-formed items: stamps move forward, offsets near the count
  task automatic rand_item(int unsigned step, output tswb_pkg::func_e op,
                           output tswb_pkg::in_item_t it);
    int unsigned r;
    int unsigned top;
    logic [31:0] rnd;
    r = $urandom_range(0, 99);
    op = (r < 45) ? tswb_pkg::FUNC_ADD : (r < 75) ? tswb_pkg::FUNC_READ :
         (r < 93) ? tswb_pkg::FUNC_EXPIRE : tswb_pkg::FUNC_CLEAR;
    it.sample_time = $urandom;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    rnd = $urandom;
    it.read_offset = rnd[tswb_pkg::OFF_W-1:0];
    if (op == tswb_pkg::FUNC_ADD && $urandom_range(0, 9) != 0)
      it.sample_time = newest_stamp + $urandom_range(0, step);
    if (op == tswb_pkg::FUNC_READ && held > 0 && $urandom_range(0, 7) != 0) begin
      top = (held > DEPTH - 1) ? DEPTH - 1 : held;
      rnd = $urandom_range(0, top);
      it.read_offset = rnd[tswb_pkg::OFF_W-1:0];
    end
  endtask

  task automatic run_phase(logic [tswb_pkg::STAMP_W-1:0] age, int unsigned sidle,
                           int unsigned rstall, int unsigned n, int unsigned step, bit hold);
    tswb_pkg::func_e    op;
    tswb_pkg::in_item_t it;
    drain();
    write_age(age);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (hold) hold_req = 1'b1;
    repeat (n) begin
      rand_item(step, op, it);
      offer_plain(op, it);
    end
  endtask

  // fill past the depth, then read, overwrite and expire a full ring
  task automatic run_fill;
    tswb_pkg::in_item_t it;
    logic [31:0]        rnd;
    drain();
    write_age(32'd700);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    it = '0;
    offer_plain(tswb_pkg::FUNC_CLEAR, it);
    repeat (FILL_ADDS) begin
      it.sample_time = newest_stamp + 1;
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
      rnd = $urandom;
      it.read_offset = rnd[tswb_pkg::OFF_W-1:0];
      offer_plain(tswb_pkg::FUNC_ADD, it);
    end
    repeat (20) begin
      rnd = $urandom;
      it.read_offset = rnd[tswb_pkg::OFF_W-1:0];
      if ($urandom_range(0, 4) == 0) begin
        it.sample_time = newest_stamp + $urandom_range(0, 2);
        offer_plain(tswb_pkg::FUNC_ADD, it);
      end else begin
        offer_plain(tswb_pkg::FUNC_READ, it);
      end
    end
    offer_plain(tswb_pkg::FUNC_EXPIRE, it);
    repeat (10) begin
      rnd = $urandom;
      it.read_offset = rnd[tswb_pkg::OFF_W-1:0];
      offer_plain(tswb_pkg::FUNC_READ, it);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: compare each accepted item, then pick the next ready
  always @(posedge clk_i) begin
    window_result_t      w;
    tswb_pkg::out_item_t o;
    if (rst_ni && m_tvalid && m_tready) begin
      o = m_tdata[$bits(tswb_pkg::out_item_t)-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none expected, expected none actual %0h",
                 $time, m_tdata);
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("sample_count", 32'(w.count), 32'(o.sample_count));
        check_field("stored", 32'(w.stored), 32'(m_tuser[0]));
        check_field("read_valid", 32'(w.rvalid), 32'(m_tuser[1]));
        check_field("read_time", w.rtime, o.read_time);
        check_field("read_x", w.rx, o.read_x);
        check_field("read_y", w.ry, o.read_y);
        check_field("read_z", w.rz, o.read_z);
      end
    end
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // directed rows, reset max_age in force
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_EXPIRE, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 10'd0, 1, 11'd0, 0, 0);
    // stamp 0 repeats the reset last stamp
    add_row(tswb_pkg::FUNC_ADD, 32'h0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 10'd0,
            1, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'h1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 10'd0,
            1, 11'd1, 1, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'h1, 32'h0, 32'h0, 32'h0, 10'd0, 1, 11'd1, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd1, 1, 11'd1, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            10'h3FF, 1, 11'd1, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'hFFFFFFFF, 32'h0, 32'h1, 32'hFFFFFFFF, 10'h3FF,
            1, 11'd2, 1, 0);
    // stamp wraps past zero
    add_row(tswb_pkg::FUNC_ADD, 32'h5, 32'h80000000, 32'h7FFFFFFF, 32'h0, 10'd0,
            1, 11'd3, 1, 0);
    add_row(tswb_pkg::FUNC_EXPIRE, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'h7FFFFFFF, 32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF,
            10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_EXPIRE, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    // clear keeps oldest index and last stamp
    add_row(tswb_pkg::FUNC_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            10'h3FF, 1, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 1, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'h7FFFFFFF, 32'h1, 32'h2, 32'h3, 10'd0, 1, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'h80000000, 32'h11111111, 32'h22222222, 32'h44444444,
            10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'h80000001, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'hF0F0F0F0,
            10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_EXPIRE, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd1, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_ADD, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h33333333,
            10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_EXPIRE, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);
    add_row(tswb_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 0, 11'd0, 0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].op, dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // random phases across idling patterns and register settings
    run_phase(32'h0, 0, 0, PHASE_N, 3, 1'b0);
    run_phase(32'hFFFFFFFF, 63, 0, PHASE_N, 1000, 1'b0);
    run_phase(32'd50, 0, 63, PHASE_N, 20, 1'b0);
    run_phase($urandom_range(0, 20000), 26, 26, PHASE_N, 3000, 1'b0);
    // long receiver hold-off while items keep coming
    run_phase(32'd200, 0, 0, PHASE_N, 60, 1'b1);
    run_fill();

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
